// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the console rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock, masked while reset is low
`define ATC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/atc_pkg.sv =====
`default_nettype none
// ============================================================================
// atc_pkg
// types, codes and helpers shared by the text console front and back ends
// ============================================================================
package atc_pkg;

    // widths cover the full parameter ranges
    localparam int ROW_W = 6;
    localparam int COL_W = 7;

    localparam logic [1:0] CMD_FEED  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_DIRTY = 2'd2;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_M     = 8'h6D;

    localparam logic [15:0] PARAM_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } t_in_item;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [5:0] cursor_col;
        logic [3:0] current_color;
        logic [7:0] cell_char;
        logic [3:0] cell_color;
        logic       dirty_found;
        logic [4:0] dirty_row;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI
    } t_esc_phase;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_DIRTY,
        OP_CR,
        OP_LF,
        OP_BKSP,
        OP_CLEAR,
        OP_TAB,
        OP_PRINT,
        OP_CUP,
        OP_EL,
        OP_CUF
    } t_op_kind;

    // classified item passed from the front end to the back end
    typedef struct packed {
        t_op_kind         kind;
        logic [7:0]       ch;
        logic [ROW_W-1:0] arg_row;
        logic [COL_W:0]   arg_col;
        logic [3:0]       pen;
        logic             rd_ok;
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_FILL,
        BK_TAB,
        BK_SCROLL,
        BK_SCROLL_END,
        BK_SCAN,
        BK_RESP
    } t_back_state;

    // sgr colour code (30-37 or 90-97) to pen, code 0 resets the pen to 0, other codes keep the old pen
    function automatic logic [3:0] sgr_pen(input logic [15:0] v, input logic [3:0] old);
        logic [15:0] b;
        logic [3:0]  p;
        begin
            b = (v >= 16'd90 && v <= 16'd97) ? v - 16'd60 : v;
            p = old;
            if (v == 16'd0) begin
                p = 4'd0;
            end else begin
                unique case (b)
                    16'd30:  p = 4'd4;
                    16'd31:  p = 4'd5;
                    16'd32:  p = 4'd8;
                    16'd33:  p = 4'd2;
                    16'd34:  p = 4'd7;
                    16'd35:  p = 4'd6;
                    16'd36:  p = 4'd3;
                    16'd37:  p = 4'd1;
                    default: p = old;
                endcase
            end
            return p;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/atc_front.sv =====
`default_nettype none
// ============================================================================
// atc_front
// takes items, runs the escape parser and pen logic, emits classified ops
// ============================================================================
module atc_front
    import atc_pkg::*;
#(
    parameter int ROW_COUNT    = 30,
    parameter int COLUMN_COUNT = 40,
    parameter int PARAM_SLOTS  = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_wr_en,
    input  wire logic     i_cfg_wr_data,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    input  wire logic     i_hold,
    output logic          o_push,
    output t_op           o_op,
    input  wire logic     i_q_ready
);

    `include "assert_macros.svh"

    localparam int SW = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;

    logic             r_enable;
    t_esc_phase       r_phase, n_phase;
    logic [SW-1:0]    r_slot, n_slot;
    logic [15:0]      r_params [PARAM_SLOTS];
    logic [15:0]      n_params [PARAM_SLOTS];
    logic [3:0]       r_pen, n_pen;

    logic             w_acc;
    logic [7:0]       w_b;
    logic [15:0]      w_sel;
    logic [19:0]      w_acc_val;
    logic [15:0]      w_p0, w_p1;
    logic [15:0]      w_r, w_c, w_n;
    logic [3:0]       w_sgr;
    logic [7:0]       w_rr8, w_rc8;

    assign o_in_stall = !i_q_ready || i_hold;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign o_push     = w_acc;
    assign w_b        = i_in_data.data_byte;

    // decimal accumulate with saturation
    assign w_sel     = r_params[r_slot];
    assign w_acc_val = ({4'd0, w_sel} << 3) + ({4'd0, w_sel} << 1)
                     + {16'd0, w_b[3:0]};

    assign w_p0 = r_params[0];
    assign w_p1 = r_params[1];
    assign w_r  = (w_p0 == 16'd0) ? 16'd0 : w_p0 - 16'd1;
    assign w_c  = (r_slot != '0 && w_p1 != 16'd0) ? w_p1 - 16'd1 : 16'd0;
    assign w_n  = (w_p0 == 16'd0) ? 16'd1 : w_p0;

    assign w_rr8 = {3'd0, i_in_data.read_row};
    assign w_rc8 = {2'd0, i_in_data.read_col};

    always_comb begin
        logic [3:0] p;
        p = r_pen;
        for (int i = 0; i < PARAM_SLOTS; i++) begin
            if (SW'(i) <= r_slot) begin
                p = sgr_pen(r_params[i], p);
            end
        end
        w_sgr = p;
    end

    always_comb begin
        n_phase  = r_phase;
        n_slot   = r_slot;
        n_params = r_params;
        n_pen    = r_pen;
        o_op     = '0;
        o_op.kind = OP_NOP;
        if (w_acc) begin
            unique case (i_in_data.cmd)
                CMD_FEED: begin
                    if (r_enable) begin
                        unique case (r_phase)
                            PH_IDLE: begin
                                if (w_b == CH_ESC) begin
                                    n_phase = PH_ESC;
                                end else if (w_b == CH_CR) begin
                                    o_op.kind = OP_CR;
                                end else if (w_b == CH_LF) begin
                                    o_op.kind = OP_LF;
                                end else if (w_b == CH_BS || w_b == CH_DEL) begin
                                    o_op.kind = OP_BKSP;
                                end else if (w_b == CH_FF) begin
                                    o_op.kind = OP_CLEAR;
                                end else if (w_b == CH_TAB) begin
                                    o_op.kind = OP_TAB;
                                end else if (w_b >= CH_SPACE && w_b <= CH_TILDE) begin
                                    o_op.kind = OP_PRINT;
                                end
                            end
                            PH_ESC: begin
                                if (w_b == CH_LBRK) begin
                                    n_phase = PH_CSI;
                                    n_slot  = '0;
                                    for (int i = 0; i < PARAM_SLOTS; i++) begin
                                        n_params[i] = 16'd0;
                                    end
                                end else begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: begin
                                if (w_b >= CH_ZERO && w_b <= CH_NINE) begin
                                    n_params[r_slot] = (w_acc_val > {4'd0, PARAM_MAX})
                                                     ? PARAM_MAX : w_acc_val[15:0];
                                end else if (w_b == CH_SEMI) begin
                                    if (int'(r_slot) < PARAM_SLOTS - 1) begin
                                        n_slot = r_slot + SW'(1);
                                    end
                                end else begin
                                    n_phase = PH_IDLE;
                                    if (w_b == CH_H || w_b == CH_F) begin
                                        o_op.kind    = OP_CUP;
                                        o_op.arg_row = (w_r >= 16'(ROW_COUNT))
                                                     ? ROW_W'(ROW_COUNT - 1) : w_r[ROW_W-1:0];
                                        o_op.arg_col = (w_c >= 16'(COLUMN_COUNT))
                                                     ? (COL_W+1)'(COLUMN_COUNT - 1)
                                                     : w_c[COL_W:0];
                                    end else if (w_b == CH_J) begin
                                        o_op.kind = OP_CLEAR;
                                    end else if (w_b == CH_K) begin
                                        o_op.kind = OP_EL;
                                    end else if (w_b == CH_C) begin
                                        o_op.kind    = OP_CUF;
                                        o_op.arg_col = (w_n >= 16'(COLUMN_COUNT))
                                                     ? (COL_W+1)'(COLUMN_COUNT) : w_n[COL_W:0];
                                    end else if (w_b == CH_M) begin
                                        n_pen = w_sgr;
                                    end
                                end
                            end
                        endcase
                    end
                end
                CMD_READ: begin
                    o_op.kind    = OP_READ;
                    o_op.arg_row = w_rr8[ROW_W-1:0];
                    o_op.arg_col = w_rc8[COL_W:0];
                    o_op.rd_ok   = (w_rr8 < 8'(ROW_COUNT)) && (w_rc8 < 8'(COLUMN_COUNT));
                end
                CMD_DIRTY: begin
                    if (r_enable) begin
                        o_op.kind = OP_DIRTY;
                    end
                end
                default: begin
                    o_op.kind = OP_NOP;
                end
            endcase
        end
        o_op.ch  = w_b;
        o_op.pen = n_pen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_phase  <= PH_IDLE;
            r_slot   <= '0;
            r_pen    <= 4'd0;
            for (int i = 0; i < PARAM_SLOTS; i++) begin
                r_params[i] <= 16'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_enable <= i_cfg_wr_data;
            end
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_pen    <= n_pen;
            r_params <= n_params;
        end
    end

    // an escape byte is always followed by csi or a return to idle
    `ATC_ASSERT_NEXT(a_esc_leaves, w_acc && r_enable && i_in_data.cmd == CMD_FEED && r_phase == PH_ESC, r_phase != PH_ESC, "escape phase held after a byte")

endmodule
`default_nettype wire

// ===== rtl/core/atc_queue.sv =====
`default_nettype none
// ============================================================================
// atc_queue
// two-entry queue of classified ops between front and back end
// ============================================================================
module atc_queue
    import atc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_ready,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    t_op        r_slots [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_op    = r_slots[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/atc_back.sv =====
`default_nettype none
// ============================================================================
// atc_back
// executes ops on the cell memory, cursor and dirty rows; holds the result
// ============================================================================
module atc_back
    import atc_pkg::*;
#(
    parameter int ROW_COUNT    = 30,
    parameter int COLUMN_COUNT = 40,
    parameter int TAB_STOP     = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_op  i_q_op,
    output logic      o_pop,
    output logic      o_init_busy,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  wire logic i_out_stall
);

    `include "assert_macros.svh"

    localparam int CELLS = ROW_COUNT * COLUMN_COUNT;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROW_COUNT);
    localparam int CW    = $clog2(COLUMN_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMN_COUNT - 1);
    localparam logic [11:0]      BLANK    = {4'd0, CH_SPACE};

    logic [11:0] r_mem [CELLS];

    t_back_state          r_state, n_state;
    t_op                  r_op, n_op;
    logic [ROW_W-1:0]     r_cur_row, n_cur_row;
    logic [COL_W-1:0]     r_cur_col, n_cur_col;
    logic [ROW_COUNT-1:0] r_dirty, n_dirty;
    logic [ROW_W-1:0]     r_f_row, n_f_row, r_f_last, n_f_last;
    logic [COL_W-1:0]     r_f_col, n_f_col;
    logic [ROW_W-1:0]     r_s_row, n_s_row, r_wr_row, n_wr_row;
    logic [COL_W-1:0]     r_s_col, n_s_col, r_wr_col, n_wr_col;
    logic                 r_wr_pend, n_wr_pend;
    logic [ROW_W-1:0]     r_scan, n_scan;
    logic                 r_cell_ok, n_cell_ok;
    logic                 r_found, n_found;
    logic [ROW_W-1:0]     r_found_row, n_found_row;
    logic                 r_init, n_init;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic [11:0]          r_rd_data;

    logic                 w_we, w_re;
    logic [ROW_W-1:0]     w_wrow, w_rrow;
    logic [COL_W-1:0]     w_wcol, w_rcol;
    logic [11:0]          w_wdata;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic                 w_out_free, w_load;
    logic [COL_W-1:0]     w_col_next;
    logic [COL_W:0]       w_cuf_sum;
    logic [COLUMN_COUNT-1:0] w_stop;

    for (genvar g = 0; g < COLUMN_COUNT; g++) begin : g_stop
        assign w_stop[g] = ((g % TAB_STOP) == 0);
    end

    assign w_waddr    = AW'(w_wrow) * AW'(COLUMN_COUNT) + AW'(w_wcol);
    assign w_raddr    = AW'(w_rrow) * AW'(COLUMN_COUNT) + AW'(w_rcol);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_col_next = r_cur_col + COL_W'(1);
    assign w_cuf_sum  = {1'b0, r_cur_col} + r_op.arg_col;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_cur_row   = r_cur_row;
        n_cur_col   = r_cur_col;
        n_dirty     = r_dirty;
        n_f_row     = r_f_row;
        n_f_col     = r_f_col;
        n_f_last    = r_f_last;
        n_s_row     = r_s_row;
        n_s_col     = r_s_col;
        n_wr_row    = r_wr_row;
        n_wr_col    = r_wr_col;
        n_wr_pend   = r_wr_pend;
        n_scan      = r_scan;
        n_cell_ok   = r_cell_ok;
        n_found     = r_found;
        n_found_row = r_found_row;
        n_init      = r_init;
        o_pop       = 1'b0;
        w_load      = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_wrow      = r_cur_row;
        w_wcol      = r_cur_col;
        w_wdata     = BLANK;
        w_rrow      = r_op.arg_row;
        w_rcol      = r_op.arg_col[COL_W-1:0];

        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_pop       = 1'b1;
                    n_op        = i_q_op;
                    n_cell_ok   = 1'b0;
                    n_found     = 1'b0;
                    n_found_row = '0;
                    n_state     = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state = BK_RESP;
                unique case (r_op.kind)
                    OP_READ: begin
                        w_re      = r_op.rd_ok;
                        n_cell_ok = r_op.rd_ok;
                    end
                    OP_DIRTY: begin
                        n_scan  = '0;
                        n_state = BK_SCAN;
                    end
                    OP_CR: begin
                        n_cur_col = '0;
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                    end
                    OP_LF: begin
                        n_cur_col = '0;
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        if (r_cur_row == LAST_ROW) begin
                            n_dirty   = '1;
                            n_s_row   = ROW_W'(1);
                            n_s_col   = '0;
                            n_wr_pend = 1'b0;
                            n_state   = BK_SCROLL;
                        end else begin
                            n_cur_row = r_cur_row + ROW_W'(1);
                            n_dirty[n_cur_row[RW-1:0]] = 1'b1;
                        end
                    end
                    OP_BKSP: begin
                        if (r_cur_col != '0) begin
                            n_cur_col = r_cur_col - COL_W'(1);
                            w_we      = 1'b1;
                            w_wcol    = n_cur_col;
                            n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        n_cur_row = '0;
                        n_cur_col = '0;
                        n_dirty   = '1;
                        n_f_row   = '0;
                        n_f_col   = '0;
                        n_f_last  = LAST_ROW;
                        n_state   = BK_FILL;
                    end
                    OP_TAB: begin
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        if (r_cur_col < LAST_COL) begin
                            n_state = BK_TAB;
                        end
                    end
                    OP_PRINT: begin
                        w_we    = 1'b1;
                        w_wdata = {r_op.pen, r_op.ch};
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        if (r_cur_col == LAST_COL) begin
                            n_cur_col = '0;
                            if (r_cur_row == LAST_ROW) begin
                                n_dirty   = '1;
                                n_s_row   = ROW_W'(1);
                                n_s_col   = '0;
                                n_wr_pend = 1'b0;
                                n_state   = BK_SCROLL;
                            end else begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                            end
                        end else begin
                            n_cur_col = w_col_next;
                        end
                    end
                    OP_CUP: begin
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        n_dirty[r_op.arg_row[RW-1:0]] = 1'b1;
                        n_cur_row = r_op.arg_row;
                        n_cur_col = r_op.arg_col[COL_W-1:0];
                    end
                    OP_EL: begin
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        n_f_row  = r_cur_row;
                        n_f_col  = r_cur_col;
                        n_f_last = r_cur_row;
                        n_state  = BK_FILL;
                    end
                    OP_CUF: begin
                        n_dirty[r_cur_row[RW-1:0]] = 1'b1;
                        n_cur_col = (w_cuf_sum >= {1'b0, LAST_COL})
                                  ? LAST_COL : w_cuf_sum[COL_W-1:0];
                    end
                    default: begin
                        n_state = BK_RESP;
                    end
                endcase
            end
            BK_FILL: begin
                w_we   = 1'b1;
                w_wrow = r_f_row;
                w_wcol = r_f_col;
                if (r_f_col == LAST_COL) begin
                    if (r_f_row == r_f_last) begin
                        n_init  = 1'b0;
                        n_state = r_init ? BK_IDLE : BK_RESP;
                    end else begin
                        n_f_row = r_f_row + ROW_W'(1);
                        n_f_col = '0;
                    end
                end else begin
                    n_f_col = r_f_col + COL_W'(1);
                end
            end
            BK_TAB: begin
                w_we      = 1'b1;
                n_cur_col = w_col_next;
                if (w_col_next == LAST_COL || w_stop[w_col_next[CW-1:0]]) begin
                    n_state = BK_RESP;
                end
            end
            BK_SCROLL: begin
                // copy one row up: read ahead, write the previous read
                w_we      = r_wr_pend;
                w_wrow    = r_wr_row;
                w_wcol    = r_wr_col;
                w_wdata   = r_rd_data;
                w_re      = 1'b1;
                w_rrow    = r_s_row;
                w_rcol    = r_s_col;
                n_wr_pend = 1'b1;
                n_wr_row  = r_s_row - ROW_W'(1);
                n_wr_col  = r_s_col;
                if (r_s_col == LAST_COL) begin
                    if (r_s_row == LAST_ROW) begin
                        n_state = BK_SCROLL_END;
                    end else begin
                        n_s_row = r_s_row + ROW_W'(1);
                        n_s_col = '0;
                    end
                end else begin
                    n_s_col = r_s_col + COL_W'(1);
                end
            end
            BK_SCROLL_END: begin
                w_we     = 1'b1;
                w_wrow   = r_wr_row;
                w_wcol   = r_wr_col;
                w_wdata  = r_rd_data;
                n_f_row  = LAST_ROW;
                n_f_col  = '0;
                n_f_last = LAST_ROW;
                n_state  = BK_FILL;
            end
            BK_SCAN: begin
                if (r_dirty[r_scan[RW-1:0]]) begin
                    n_dirty[r_scan[RW-1:0]] = 1'b0;
                    n_found     = 1'b1;
                    n_found_row = r_scan;
                    n_state     = BK_RESP;
                end else if (r_scan == LAST_ROW) begin
                    n_state = BK_RESP;
                end else begin
                    n_scan = r_scan + ROW_W'(1);
                end
            end
            BK_RESP: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_FILL;
            r_init    <= 1'b1;
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_dirty   <= '1;
            r_f_row   <= '0;
            r_f_col   <= '0;
            r_f_last  <= LAST_ROW;
            r_wr_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_init    <= n_init;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_dirty   <= n_dirty;
            r_f_row   <= n_f_row;
            r_f_col   <= n_f_col;
            r_f_last  <= n_f_last;
            r_wr_pend <= n_wr_pend;
            r_out_valid <= (r_out_valid && i_out_stall) || w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_s_row     <= n_s_row;
        r_s_col     <= n_s_col;
        r_wr_row    <= n_wr_row;
        r_wr_col    <= n_wr_col;
        r_scan      <= n_scan;
        r_cell_ok   <= n_cell_ok;
        r_found     <= n_found;
        r_found_row <= n_found_row;
        if (w_load) begin
            r_out.cursor_row    <= r_cur_row[4:0];
            r_out.cursor_col    <= r_cur_col[5:0];
            r_out.current_color <= r_op.pen;
            r_out.cell_char     <= r_cell_ok ? r_rd_data[7:0] : 8'd0;
            r_out.cell_color    <= r_cell_ok ? r_rd_data[11:8] : 4'd0;
            r_out.dirty_found   <= r_found;
            r_out.dirty_row     <= r_found_row[4:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_init_busy = r_init;

    `ATC_ASSERT(a_col_range, int'(r_cur_col) < COLUMN_COUNT, "cursor column off screen")
    `ATC_ASSERT(a_row_range, int'(r_cur_row) < ROW_COUNT, "cursor row off screen")
    `ATC_ASSERT(a_idle_no_write, r_state != BK_IDLE || !w_we, "memory written while idle")
    `ATC_ASSERT_NEXT(a_resp_loads, r_state == BK_RESP && w_out_free, r_out_valid, "result not presented")

endmodule
`default_nettype wire

// ===== rtl/core/ansi_text_console_top.sv =====
`default_nettype none
// ============================================================================
// ansi_text_console_top
// character-cell text console with an ansi escape parser
// ============================================================================
// One result per accepted item. The front end parses each item in the cycle
// it is taken and hands it through a two-entry queue to the back end, which
// owns the cell memory (one write and one read port). A read, cursor move,
// carriage return or printable byte is popped, executed and answered in the
// back end; tab and erase to end of line blank one cell at a time; a dirty-row
// request scans one row per cycle (up to ROW_COUNT); clear and scroll rewrite
// the whole cell memory, all bound by the single memory write port. After
// reset the memory is blanked in a pass over all ROW_COUNT*COLUMN_COUNT cells
// (1200 by default) during which no item is taken; the enable register can
// be written at any time.
module ansi_text_console_top
    import atc_pkg::*;
#(
    parameter int ROW_COUNT    = 30,
    parameter int COLUMN_COUNT = 40,
    parameter int PARAM_SLOTS  = 4,
    parameter int TAB_STOP     = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_wr_en,
    input  wire logic      i_cfg_wr_data,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    logic w_push, w_q_ready, w_q_valid, w_pop, w_init_busy;
    t_op  w_push_op, w_head_op;

    atc_front #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .PARAM_SLOTS  (PARAM_SLOTS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_hold        (w_init_busy),
        .o_push        (w_push),
        .o_op          (w_push_op),
        .i_q_ready     (w_q_ready)
    );

    atc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_op    (w_head_op),
        .i_pop   (w_pop)
    );

    atc_back #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT),
        .TAB_STOP     (TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_op      (w_head_op),
        .o_pop       (w_pop),
        .o_init_busy (w_init_busy),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
